// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// edge of clk and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every sampled edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold at the same edge.
`define ASSERT_IMPLY(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

// When the trigger holds, the consequence must hold at the next edge.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rsts_pkg.sv =====
`default_nettype none

package rsts_pkg;

  // Largest rank value that has a bin of its own; larger values saturate.
  localparam int TOP_RANK    = 1023;
  // Largest number of beats counted in one row.
  localparam int MAX_COLUMNS = 4096;

  localparam int BINS  = TOP_RANK + 1;
  localparam int BIN_W = $clog2(BINS);
  localparam int SW_W  = $clog2(BINS + 1);
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int ARG_W = CNT_W + 1;

  // Field widths of the stream and configuration port.
  localparam int RANK_W   = 10;
  localparam int CFG_W    = 13;
  localparam int RSUM_W   = 25;
  localparam int TSUM_W   = 36;
  localparam int LEN_W    = 13;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 80;

endpackage

`default_nettype wire

// ===== rtl/rsts_ram.sv =====
`default_nettype none

module rsts_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/rank_sum_tie_statistic.sv =====
`default_nettype none

`include "assert_macros.svh"

// Channel     Direction  Beat contents
// s_axis_*    in         tdata[9:0] rank_value; tlast marks the last beat of a row
// m_axis_*    out        tdata[24:0] rank_sum_doubled, [60:25] tie_sum,
//                        [73:61] row_length; tuser row_overflow
// cfg_*       in         cfg_wdata is group1_size, written when cfg_wen is high
//
// While a row is loading the two histogram RAMs are read at each beat's value
// in the cycle of acceptance and written back with the incremented counts in
// the next, during which s_axis_tready is low.
// After the last beat of a row the sweep reads every bin once, clears it behind
// the read and retires it through a three-stage multiply pipeline; the
// sequencer then passes through a done state, from which the result enters the
// output register.
// After reset a clearing pass writes zero into every bin with s_axis_tready
// low; configuration writes are taken throughout.
// The output register holds a result while the next row loads; a sweep that
// finishes before that result has been taken waits for it.

module rank_sum_tie_statistic
  import rsts_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wen,
  input  wire logic [CFG_W-1:0]       cfg_wdata,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [9:0] rank_value
  input  wire logic                   s_axis_tlast,  // row_last
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,  // rank_sum_doubled, tie_sum,
                                                     // row_length
  output logic                        m_axis_tuser   // row_overflow
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_UPDATE,
    ST_SWEEP,
    ST_DONE
  } state_t;

  state_t state;

  // Control registers.
  logic [CFG_W-1:0]  group1_size;
  logic [SW_W-1:0]   sw_addr;
  logic [CNT_W-1:0]  col_cnt;
  logic              ovf;
  logic              rd_valid;
  logic              a_valid;
  logic              b_valid;
  logic [CNT_W-1:0]  start;
  logic [RSUM_W-1:0] rsum;
  logic [TSUM_W-1:0] tsum;

  // Beat held between the read and the write-back.
  logic [BIN_W-1:0]  upd_bin;
  logic              upd_count;
  logic              upd_group;
  logic              upd_last;

  // Sweep pipeline payload.
  logic [BIN_W-1:0]   rd_bin;
  logic [CNT_W-1:0]   a_t;
  logic [CNT_W-1:0]   a_g;
  logic [ARG_W-1:0]   a_arg;
  logic [2*CNT_W-1:0] a_tsq;
  logic [CNT_W-1:0]   b_t;
  logic [CNT_W+ARG_W-1:0] b_prod;
  logic [3*CNT_W-1:0] b_cube;
  logic [3*CNT_W-1:0] b_cube_less;

  // Output register.
  logic [RSUM_W-1:0] out_rsum;
  logic [TSUM_W-1:0] out_tsum;
  logic [LEN_W-1:0]  out_len;
  logic              out_ovf;

  // RAM ports.
  logic [BIN_W-1:0] ram_raddr;
  logic [BIN_W-1:0] ram_waddr;
  logic             tot_we;
  logic             grp_we;
  logic [CNT_W-1:0] tot_wdata;
  logic [CNT_W-1:0] grp_wdata;
  logic [CNT_W-1:0] tot_rdata;
  logic [CNT_W-1:0] grp_rdata;

  logic [BIN_W-1:0] in_bin;
  logic             in_accept;
  logic             sweep_done;

  // Values beyond the top bin are counted in the top bin.
  assign in_bin = (32'(s_axis_tdata[RANK_W-1:0]) > TOP_RANK) ? BIN_W'(TOP_RANK)
                                                             : BIN_W'(s_axis_tdata[RANK_W-1:0]);

  assign s_axis_tready = (state == ST_LOAD);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign sweep_done    = (sw_addr == SW_W'(BINS)) && !rd_valid && !a_valid && !b_valid;
  assign b_cube_less   = b_cube - (3*CNT_W)'(b_t);

  assign ram_raddr = (state == ST_SWEEP) ? sw_addr[BIN_W-1:0] : in_bin;

  // One write port per RAM: the clearing pass, the write-back of a beat, or
  // the clear that follows each sweep read.
  always_comb begin
    tot_we    = 1'b0;
    grp_we    = 1'b0;
    ram_waddr = rd_bin;
    tot_wdata = '0;
    grp_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        tot_we    = 1'b1;
        grp_we    = 1'b1;
        ram_waddr = sw_addr[BIN_W-1:0];
      end
      ST_UPDATE: begin
        tot_we    = upd_count;
        grp_we    = upd_group;
        ram_waddr = upd_bin;
        tot_wdata = tot_rdata + CNT_W'(1);
        grp_wdata = grp_rdata + CNT_W'(1);
      end
      ST_SWEEP: begin
        tot_we = rd_valid;
        grp_we = rd_valid;
      end
      default: begin
      end
    endcase
  end

  rsts_ram #(
    .WIDTH (CNT_W),
    .DEPTH (BINS)
  ) u_total_ram (
    .clk   (clk),
    .we    (tot_we),
    .waddr (ram_waddr),
    .wdata (tot_wdata),
    .raddr (ram_raddr),
    .rdata (tot_rdata)
  );

  rsts_ram #(
    .WIDTH (CNT_W),
    .DEPTH (BINS)
  ) u_group_ram (
    .clk   (clk),
    .we    (grp_we),
    .waddr (ram_waddr),
    .wdata (grp_wdata),
    .raddr (ram_raddr),
    .rdata (grp_rdata)
  );

  // Sequencer, row counters, sweep accumulators and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      group1_size   <= '0;
      sw_addr       <= '0;
      col_cnt       <= '0;
      ovf           <= 1'b0;
      rd_valid      <= 1'b0;
      a_valid       <= 1'b0;
      b_valid       <= 1'b0;
      start         <= CNT_W'(1);
      rsum          <= '0;
      tsum          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        group1_size <= cfg_wdata;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      a_valid  <= rd_valid;
      b_valid  <= a_valid;
      rd_valid <= 1'b0;
      if (rd_valid) begin
        start <= start + tot_rdata;
      end
      if (b_valid) begin
        rsum <= rsum + RSUM_W'(b_prod);
        tsum <= tsum + TSUM_W'(b_cube_less);
      end

      unique case (state)
        ST_CLEAR: begin
          if (sw_addr == SW_W'(BINS - 1)) begin
            sw_addr <= '0;
            state   <= ST_LOAD;
          end else begin
            sw_addr <= sw_addr + SW_W'(1);
          end
        end
        ST_LOAD: begin
          if (in_accept) begin
            upd_bin   <= in_bin;
            upd_last  <= s_axis_tlast;
            upd_count <= 1'b0;
            upd_group <= 1'b0;
            if (32'(col_cnt) < MAX_COLUMNS) begin
              upd_count <= 1'b1;
              upd_group <= 32'(col_cnt) < 32'(group1_size);
              col_cnt   <= col_cnt + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state <= upd_last ? ST_SWEEP : ST_LOAD;
        end
        ST_SWEEP: begin
          if (sw_addr != SW_W'(BINS)) begin
            rd_valid <= 1'b1;
            rd_bin   <= sw_addr[BIN_W-1:0];
            sw_addr  <= sw_addr + SW_W'(1);
          end else if (sweep_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_rsum      <= rsum;
            out_tsum      <= tsum;
            out_len       <= LEN_W'(col_cnt);
            out_ovf       <= ovf;
            m_axis_tvalid <= 1'b1;
            rsum          <= '0;
            tsum          <= '0;
            start         <= CNT_W'(1);
            col_cnt       <= '0;
            ovf           <= 1'b0;
            sw_addr       <= '0;
            state         <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // Sweep datapath: a tie of t values starting at rank s has doubled average
  // rank 2s + t - 1; every group-one member of the tie adds that figure, and
  // the tie adds t^3 - t to the tie sum. Empty bins contribute zero.
  always_ff @(posedge clk) begin
    a_t   <= tot_rdata;
    a_g   <= grp_rdata;
    a_arg <= ARG_W'(start) + ARG_W'(start) + ARG_W'(tot_rdata) - ARG_W'(1);
    a_tsq <= (2*CNT_W)'(tot_rdata) * (2*CNT_W)'(tot_rdata);

    b_t    <= a_t;
    b_prod <= (CNT_W+ARG_W)'(a_g) * (CNT_W+ARG_W)'(a_arg);
    b_cube <= (3*CNT_W)'(a_tsq) * (3*CNT_W)'(a_t);
  end

  assign m_axis_tdata = OUT_TDATA_W'({out_len, out_tsum, out_rsum});
  assign m_axis_tuser = out_ovf;

  `ASSERT_NEXT(a_two_cycle_beat, in_accept, !s_axis_tready, "beat accepted back to back")
  `ASSERT_IMPLY(a_no_load_in_sweep, s_axis_tready, !rd_valid && !a_valid && !b_valid, "load during sweep")
  `ASSERT_ALWAYS(a_count_bound, 32'(col_cnt) <= MAX_COLUMNS, "column count beyond capacity")
  `ASSERT_IMPLY(a_result_source, $rose(m_axis_tvalid), $past(state) == ST_DONE, "result outside done state")

endmodule

`default_nettype wire
